[sv/slpb_pkg.sv]
// Shared types and constants for the status LED pattern blinker.
package slpb_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    // Pattern dwell times in milliseconds
    localparam int DWELL_SHORT = 200;
    localparam int DWELL_MID   = 2000;
    localparam int DWELL_LONG  = 4000;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_CONN = 2'd1,
        OP_BLINK    = 2'd2
    } t_op;

    localparam logic [2:0] CONN_STARTING   = 3'd0;
    localparam logic [2:0] CONN_OK         = 3'd1;
    localparam logic [2:0] CONN_NOT_CONN   = 3'd2;
    localparam logic [2:0] CONN_WIFI       = 3'd3;
    localparam logic [2:0] CONN_SEARCHING  = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  conn_state;
        logic [7:0]  blink_count;
        logic [15:0] blink_interval;
    } t_item;

    typedef struct packed {
        logic led_level;
        logic blink_active;
    } t_result;

endpackage

[sv/status_led_pattern_blinker.sv]
// Top level of the status LED pattern blinker: input and result registers.
//
// Usage
//   Input channel: i_in_valid / o_in_stall carry one beat of operation,
//   conn_state, blink_count and blink_interval. A beat is taken at a rising
//   edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one result beat
//   (led_level, blink_active) for every input beat, in order.
//   Path: an input beat goes to the input register, then through the update
//   logic into the result register, which drives o_out_valid.
//   Throughput: one beat per cycle while i_out_stall is low; the state
//   update is two saturating increments and compares, done combinationally
//   between the two registers.
//   Stall: while the receiver holds i_out_stall, the result register holds
//   its beat, the pending input beat waits in the input register, and
//   o_in_stall rises once that register is full. No beat is dropped.
//   Reset (synchronous, i_rst_n low): both registers empty, LED state low,
//   connection state "starting", all counters and blink count zero.
//   Operation codes: tick, set connection state, start blink; code three
//   changes nothing and still returns a result beat.
module status_led_pattern_blinker
    import slpb_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_conn_state,
    input  logic [7:0]  i_blink_count,
    input  logic [15:0] i_blink_interval,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_led_level,
    output logic        o_blink_active
);

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_res;
    t_result next_res;
    logic    out_free, proc, in_take;

    // Result register can take a new beat when empty or being drained
    assign out_free   = !r_out_vld || !i_out_stall;
    assign proc       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || proc) begin
            r_in_vld <= i_in_valid;
        end
    end

    // Payload needs no reset; load only on acceptance
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.operation      <= i_operation;
            r_item.conn_state     <= i_conn_state;
            r_item.blink_count    <= i_blink_count;
            r_item.blink_interval <= i_blink_interval;
        end
    end

    slpb_core #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (proc),
        .i_item  (r_item),
        .o_next  (next_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_res <= next_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_led_level    = r_res.led_level;
    assign o_blink_active = r_res.blink_active;

endmodule

[sv/slpb_core.sv]
// LED state registers and the per-beat update logic.
module slpb_core
    import slpb_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_proc,
    input  t_item   i_item,
    output t_result o_next
);

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [TIMER_WIDTH-1:0] DW_SHORT = TIMER_WIDTH'(DWELL_SHORT);
    localparam logic [TIMER_WIDTH-1:0] DW_MID   = TIMER_WIDTH'(DWELL_MID);
    localparam logic [TIMER_WIDTH-1:0] DW_LONG  = TIMER_WIDTH'(DWELL_LONG);

    logic                   r_led,   n_led;
    logic [2:0]             r_mode,  n_mode;
    logic [TIMER_WIDTH-1:0] r_pat,   n_pat;
    logic [7:0]             r_left,  n_left;
    logic [15:0]            r_per,   n_per;
    logic [TIMER_WIDTH-1:0] r_blel,  n_blel;

    logic [TIMER_WIDTH-1:0] pat_inc, blel_inc, dwell;
    logic                   toggling;

    assign pat_inc  = (r_pat  == CNT_MAX) ? CNT_MAX : r_pat  + 1'b1;
    assign blel_inc = (r_blel == CNT_MAX) ? CNT_MAX : r_blel + 1'b1;

    always_comb begin
        toggling = 1'b1;
        dwell    = DW_SHORT;
        unique case (r_mode)
            CONN_NOT_CONN:  dwell = DW_SHORT;
            CONN_WIFI:      dwell = r_led ? DW_MID  : DW_SHORT;
            CONN_SEARCHING: dwell = r_led ? DW_LONG : DW_MID;
            default:        toggling = 1'b0;
        endcase
    end

    always_comb begin
        n_led  = r_led;
        n_mode = r_mode;
        n_pat  = r_pat;
        n_left = r_left;
        n_per  = r_per;
        n_blel = r_blel;
        if (i_proc) begin
            unique case (t_op'(i_item.operation))
                OP_TICK: begin
                    n_pat  = pat_inc;
                    n_blel = blel_inc;
                    if (r_left != 8'd0) begin
                        if (CMP_W'(blel_inc) >= CMP_W'(r_per)) begin
                            n_led  = ~r_led;
                            n_blel = '0;
                            if (!r_led) begin
                                n_left = r_left - 8'd1;
                            end
                        end
                    end else if (r_mode == CONN_STARTING) begin
                        n_led = 1'b0;
                    end else if (r_mode == CONN_OK) begin
                        n_led = 1'b1;
                    end else if (toggling && pat_inc >= dwell) begin
                        n_led = ~r_led;
                        n_pat = '0;
                    end
                end
                OP_SET_CONN: begin
                    n_mode = i_item.conn_state;
                end
                OP_BLINK: begin
                    n_per  = i_item.blink_interval;
                    n_left = i_item.blink_count;
                    n_led  = ~r_led;
                    n_blel = '0;
                end
                default: begin
                    // unknown operation: hold everything
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led  <= 1'b0;
            r_mode <= CONN_STARTING;
            r_pat  <= '0;
            r_left <= 8'd0;
            r_per  <= 16'd0;
            r_blel <= '0;
        end else begin
            r_led  <= n_led;
            r_mode <= n_mode;
            r_pat  <= n_pat;
            r_left <= n_left;
            r_per  <= n_per;
            r_blel <= n_blel;
        end
    end

    assign o_next.led_level    = n_led;
    assign o_next.blink_active = (n_left != 8'd0);

    // On a tick with blinks left, the blink count holds or drops by one
    a_left_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && t_op'(i_item.operation) == OP_TICK && r_left != 8'd0)
        |=> (r_left == $past(r_left) || r_left == $past(r_left) - 8'd1))
        else $error("blink count moved by more than one");

    // A start-blink beat clears the blink timer and flips the level
    a_blink_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && t_op'(i_item.operation) == OP_BLINK)
        |=> (r_blel == '0 && r_led != $past(r_led)))
        else $error("start blink did not toggle and clear");

    // Setting the connection state leaves the level alone
    a_set_conn_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && t_op'(i_item.operation) == OP_SET_CONN) |=> $stable(r_led))
        else $error("connection state write changed the level");

endmodule
